### rtl/core/tensor_transpose_address_gen_assert.svh
// Assertion macros shared by the checker of the transpose address generator.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef TENSOR_TRANSPOSE_ADDRESS_GEN_ASSERT_SVH
`define TENSOR_TRANSPOSE_ADDRESS_GEN_ASSERT_SVH

// Same-cycle implication, switched off while reset is applied.
`define TTA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("transpose address generator check failed");

// Next-cycle implication, switched off while reset is applied.
`define TTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("transpose address generator check failed");

`endif

### rtl/core/tta_pkg.sv
// Shared constants, register codes and types of the transpose address generator.
// Depends on nothing; every other file but the assertion macros header imports it.
package tta_pkg;

	localparam int MAX_DIMS_DEF   = 6;
	localparam int DIM_BITS_DEF   = 10;
	localparam int INDEX_BITS_DEF = 32;

	// The linear index and the quotient chain are always this wide.
	localparam int DIV_W         = 32;
	localparam int STEPS_PER_STG = 4;
	localparam int STG_PER_DIGIT = DIV_W / STEPS_PER_STG;

	localparam int CFG_W     = 60;
	localparam int CFG_IDX_W = 3;
	localparam int RANK_W    = 3;
	localparam int SHAPE_W   = 60;
	localparam int PERM_W    = 18;
	localparam int AXIS_BITS = 3;
	localparam int COUNT_W   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RANK        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERM_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_SHAPE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SHAPE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERMUTATION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT = 3'd5;

	typedef struct packed {
		logic valid;
		logic oor;
	} tta_ctl_t;

endpackage

### rtl/core/tta_stream_if.sv
// Word channels of the transpose address generator: request and response.
// Depends on tta_pkg for the field widths.
interface tta_req_if;
	import tta_pkg::*;
	logic             valid;
	logic             ready;
	logic [DIV_W-1:0] out_index;
	modport source (output valid, output out_index, input ready);
	modport sink (input valid, input out_index, output ready);
endinterface

interface tta_rsp_if;
	import tta_pkg::*;
	logic             valid;
	logic             ready;
	logic [DIV_W-1:0] src_index;
	logic             out_of_range;
	modport source (output valid, output src_index, output out_of_range, input ready);
	modport sink (input valid, input src_index, input out_of_range, output ready);
endinterface

### rtl/core/tensor_transpose_address_gen.sv
// Top level of the transpose gather-address generator.
// Depends on tta_pkg, tta_stream_if and tta_div_stage.
//
// Usage: each request word carries a linear output index; the block returns one
// response word per request with the linear source index to read and a flag that
// marks an index at or beyond the element count (its source index is then zero).
// Shapes, rank, permutation and element count are set through the write port
// while no word is in flight; the stride table behind them is registered and
// rebuilt one suffix product at a time after the last write.
// The index is split into digits by a chain of restoring dividers, four quotient
// bits per stage, eight stages per dimension, innermost dimension first. Then
// one stage multiplies digits by strides and one stage sums them into the
// response register. One word is accepted every cycle while no response is
// held. The whole pipeline advances together: when the receiver stalls a held
// response, every stage holds and the request side sees ready low, so no word
// is lost or repeated. Reset clears all valid bits and all configuration
// registers, which selects rank zero.
module tensor_transpose_address_gen import tta_pkg::*; #(
	parameter int MAX_DIMS   = MAX_DIMS_DEF,
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	tta_req_if.sink              req,
	tta_rsp_if.source            rsp
);

	localparam int NSTG  = MAX_DIMS * STG_PER_DIGIT;
	localparam int RW    = $clog2(MAX_DIMS + 1);
	localparam int SHP_W = (MAX_DIMS * DIM_BITS > SHAPE_W) ? MAX_DIMS * DIM_BITS : SHAPE_W;
	localparam int PRM_W = (MAX_DIMS * AXIS_BITS > PERM_W) ? MAX_DIMS * AXIS_BITS : PERM_W;
	localparam int DG_W  = MAX_DIMS * DIV_W;

	// Configuration registers.
	logic [RANK_W-1:0]  rank_q;
	logic [RANK_W-1:0]  pcnt_q;
	logic [SHAPE_W-1:0] in_shape_q;
	logic [SHAPE_W-1:0] out_shape_q;
	logic [PERM_W-1:0]  perm_q;
	logic [COUNT_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q      <= '0;
			pcnt_q      <= '0;
			in_shape_q  <= '0;
			out_shape_q <= '0;
			perm_q      <= '0;
			total_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANK:        rank_q      <= cfg_data[RANK_W-1:0];
				REG_PERM_COUNT:  pcnt_q      <= cfg_data[RANK_W-1:0];
				REG_IN_SHAPE:    in_shape_q  <= cfg_data[SHAPE_W-1:0];
				REG_OUT_SHAPE:   out_shape_q <= cfg_data[SHAPE_W-1:0];
				REG_PERMUTATION: perm_q      <= cfg_data[PERM_W-1:0];
				REG_TOTAL_COUNT: total_q     <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Settings derived from the registers. Slots beyond a register's width read as zero.
	logic [RW-1:0]        r;
	logic [RW-1:0]        pc;
	logic [SHP_W-1:0]     in_pad;
	logic [SHP_W-1:0]     out_pad;
	logic [PRM_W-1:0]     perm_pad;
	logic [MAX_DIMS-1:0]  active;
	logic [MAX_DIMS-1:0]  size_zero;
	logic [DIM_BITS-1:0]  divisor [MAX_DIMS];
	logic [RW-1:0]        axis_r  [MAX_DIMS];
	logic [INDEX_BITS-1:0] suf_d  [MAX_DIMS+1];
	logic [INDEX_BITS-1:0] suf_q  [MAX_DIMS+1];
	logic [INDEX_BITS-1:0] stride_d [MAX_DIMS];
	logic [INDEX_BITS-1:0] stride_q [MAX_DIMS];
	logic [AXIS_BITS-1:0] axis_v  [MAX_DIMS];
	logic [DIM_BITS-1:0]  osz     [MAX_DIMS];
	logic [MAX_DIMS-1:0]  axis_ok;

	assign r        = (int'(rank_q) > MAX_DIMS) ? RW'(MAX_DIMS) : RW'(rank_q);
	assign pc       = (int'(pcnt_q) > MAX_DIMS) ? RW'(MAX_DIMS) : RW'(pcnt_q);
	assign in_pad   = SHP_W'(in_shape_q);
	assign out_pad  = SHP_W'(out_shape_q);
	assign perm_pad = PRM_W'(perm_q);

	// Slot s holds a dimension when s >= MAX_DIMS - rank. Unused slots and zero-sized
	// ones divide by one so the quotient chain carries the index through unchanged.
	always_comb begin
		for (int s = 0; s < MAX_DIMS; s++) begin
			osz[s]       = out_pad[s*DIM_BITS +: DIM_BITS];
			active[s]    = (s >= MAX_DIMS - int'(r));
			size_zero[s] = active[s] && (osz[s] == '0);
			divisor[s]   = (!active[s] || osz[s] == '0) ? DIM_BITS'(1) : osz[s];
		end
	end

	// Input axis of each output slot. An explicit permutation slot that falls past the
	// last slot maps to the rank, which later gives stride one.
	always_comb begin
		for (int s = 0; s < MAX_DIMS; s++) begin
			axis_v[s]  = '0;
			axis_r[s]  = r;
			axis_ok[s] = 1'b0;
			if (active[s]) begin
				if (pc != '0) begin
					if (s + int'(r) - int'(pc) < MAX_DIMS) begin
						axis_v[s]  = perm_pad[(s + int'(r) - int'(pc))*AXIS_BITS +: AXIS_BITS];
						axis_ok[s] = (int'(axis_v[s]) < int'(r));
					end
				end else begin
					axis_r[s]  = RW'(MAX_DIMS - 1 - s);
					axis_ok[s] = 1'b1;
				end
			end
		end
	end

	// Suffix products of the input shape: suf[t] is the product of input dimensions t
	// up to rank - 1. Each entry is one multiply away from the next, so the table
	// settles one entry per cycle after a write.
	always_comb begin
		suf_d[MAX_DIMS] = INDEX_BITS'(1);
		for (int t = 0; t < MAX_DIMS; t++) begin
			if (t < int'(r)) begin
				suf_d[t] = suf_q[t+1] *
					INDEX_BITS'(in_pad[(t + MAX_DIMS - int'(r))*DIM_BITS +: DIM_BITS]);
			end else begin
				suf_d[t] = INDEX_BITS'(1);
			end
		end
	end

	// The stride of an axis is the product of all input dimensions inside it.
	always_comb begin
		for (int s = 0; s < MAX_DIMS; s++) begin
			stride_d[s] = INDEX_BITS'(1);
			if (axis_ok[s]) begin
				for (int t = 1; t <= MAX_DIMS; t++) begin
					if (pc != '0) begin
						if (t == int'(axis_v[s]) + 1) begin
							stride_d[s] = suf_q[t];
						end
					end else if (t == int'(axis_r[s]) + 1) begin
						stride_d[s] = suf_q[t];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t <= MAX_DIMS; t++) begin
				suf_q[t] <= INDEX_BITS'(1);
			end
			for (int s = 0; s < MAX_DIMS; s++) begin
				stride_q[s] <= INDEX_BITS'(1);
			end
		end else begin
			for (int t = 0; t <= MAX_DIMS; t++) begin
				suf_q[t] <= suf_d[t];
			end
			for (int s = 0; s < MAX_DIMS; s++) begin
				stride_q[s] <= stride_d[s];
			end
		end
	end

	// Pipeline advance: everything moves unless a response is held by the receiver.
	logic     adv;
	tta_ctl_t out_ctl_s;

	assign adv       = !out_ctl_s.valid || rsp.ready;
	assign req.ready = adv;

	// Entry stage and the division chain. Index 0 is the entry register.
	tta_ctl_t            ctl_s  [NSTG+1];
	logic [DIV_W-1:0]    work_s [NSTG+1];
	logic [DIM_BITS-1:0] part_s [NSTG+1];
	logic [DG_W-1:0]     digs_s [NSTG+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (adv) begin
			ctl_s[0].valid <= req.valid;
			ctl_s[0].oor   <= (req.out_index >= total_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			work_s[0] <= req.out_index;
		end
	end

	assign part_s[0] = '0;
	assign digs_s[0] = '0;

	for (genvar g = 0; g < NSTG; g++) begin : g_div
		localparam int SLOT = MAX_DIMS - 1 - g / STG_PER_DIGIT;
		tta_div_stage #(
			.MAX_DIMS (MAX_DIMS),
			.DIM_BITS (DIM_BITS),
			.SLOT     (SLOT),
			.FIRST    ((g % STG_PER_DIGIT) == 0),
			.LAST     ((g % STG_PER_DIGIT) == STG_PER_DIGIT - 1)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.divisor   (divisor[SLOT]),
			.size_zero (size_zero[SLOT]),
			.skip      (!active[SLOT]),
			.ctl_i     (ctl_s[g]),
			.work_i    (work_s[g]),
			.part_i    (part_s[g]),
			.digs_i    (digs_s[g]),
			.ctl_o     (ctl_s[g+1]),
			.work_o    (work_s[g+1]),
			.part_o    (part_s[g+1]),
			.digs_o    (digs_s[g+1])
		);
	end

	// Product stage: each digit times the stride of its input axis, modulo the index width.
	tta_ctl_t              prd_ctl_s;
	logic [INDEX_BITS-1:0] prd_s [MAX_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prd_ctl_s <= '0;
		end else if (adv) begin
			prd_ctl_s <= ctl_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s < MAX_DIMS; s++) begin
				prd_s[s] <= INDEX_BITS'(digs_s[NSTG][s*DIV_W +: DIV_W]) * stride_q[s];
			end
		end
	end

	// Sum stage, which is also the response register.
	logic [INDEX_BITS-1:0] sum_d;
	logic [DIV_W-1:0]      out_src_s;

	always_comb begin
		sum_d = '0;
		for (int s = 0; s < MAX_DIMS; s++) begin
			sum_d = sum_d + prd_s[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl_s <= '0;
		end else if (adv) begin
			out_ctl_s <= prd_ctl_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_src_s <= prd_ctl_s.oor ? '0 : DIV_W'(sum_d);
		end
	end

	assign rsp.valid        = out_ctl_s.valid;
	assign rsp.src_index    = out_src_s;
	assign rsp.out_of_range = out_ctl_s.oor;

endmodule

### rtl/core/tta_div_stage.sv
// One register stage of the mixed-radix split: a few restoring division steps.
// Depends on tta_pkg; instantiated in a chain by the top level.
module tta_div_stage import tta_pkg::*; #(
	parameter int MAX_DIMS = MAX_DIMS_DEF,
	parameter int DIM_BITS = DIM_BITS_DEF,
	parameter int SLOT     = 0,
	parameter bit FIRST    = 1'b0,
	parameter bit LAST     = 1'b0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [DIM_BITS-1:0]       divisor,
	input  logic                      size_zero,
	input  logic                      skip,
	input  tta_ctl_t                  ctl_i,
	input  logic [DIV_W-1:0]          work_i,
	input  logic [DIM_BITS-1:0]       part_i,
	input  logic [MAX_DIMS*DIV_W-1:0] digs_i,
	output tta_ctl_t                  ctl_o,
	output logic [DIV_W-1:0]          work_o,
	output logic [DIM_BITS-1:0]       part_o,
	output logic [MAX_DIMS*DIV_W-1:0] digs_o
);

	logic [DIV_W-1:0]          w;
	logic [DIM_BITS-1:0]       p;
	logic [DIM_BITS:0]         t;
	logic [DIV_W-1:0]          w_nxt;
	logic [DIV_W-1:0]          digit;
	logic [MAX_DIMS*DIV_W-1:0] dg;

	// The work word shifts the dividend out at the top and the quotient in at the bottom.
	always_comb begin
		w = work_i;
		p = FIRST ? '0 : part_i;
		t = '0;
		for (int k = 0; k < STEPS_PER_STG; k++) begin
			t = {p, w[DIV_W-1]};
			w = {w[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
				w[0] = 1'b1;
			end
			p = t[DIM_BITS-1:0];
		end
		w_nxt = w;
		dg = digs_i;
		digit = '0;
		if (LAST) begin
			// A zero-sized dimension was divided by one: its digit takes the whole quotient.
			if (skip) begin
				digit = '0;
			end else if (size_zero) begin
				digit = w;
			end else begin
				digit = {{(DIV_W-DIM_BITS){1'b0}}, p};
			end
			if (size_zero) begin
				w_nxt = '0;
			end
			dg[SLOT*DIV_W +: DIV_W] = digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_o <= w_nxt;
			part_o <= p;
			digs_o <= dg;
		end
	end

endmodule

### rtl/core/tta_checker.sv
// Port-level checker of the transpose address generator and its bind statement.
// Depends on tta_pkg and the assertion macros header.
`include "tensor_transpose_address_gen_assert.svh"

module tta_checker import tta_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [DIV_W-1:0] src_index,
	input logic             out_of_range
);

	// A held response word keeps its payload.
	`TTA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(src_index) && $stable(out_of_range))

	// A flagged index always reads source zero.
	`TTA_ASSERT_IMPL(a_oor_zero, clk, arst_n, rsp_valid && out_of_range, src_index == '0)

	// The request side is open exactly when the response register can move.
	`TTA_ASSERT_IMPL(a_ready_follows, clk, arst_n, req_valid || !req_valid, req_ready == (!rsp_valid || rsp_ready))

	// While the response is stalled no request is taken in the next cycle either, unless the receiver then takes it.
	`TTA_ASSERT_NEXT(a_stall_blocks, clk, arst_n, rsp_valid && !rsp_ready, !req_ready || rsp_ready)

endmodule

bind tensor_transpose_address_gen tta_checker u_tta_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.src_index    (rsp.src_index),
	.out_of_range (rsp.out_of_range)
);
